// ===== src/rpn_pkg.sv =====
// -----------------------------------------------------------------------------
// rpn_pkg
// Types, codes and constants shared by the relative path normaliser.
// -----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned CNT_W       = 17;
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QAW         = $clog2(QDEPTH);
	localparam int unsigned QCW         = $clog2(QDEPTH + 1);

	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 16'd4096;
	localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

	// Register index decoded from the word-aligned byte address.
	localparam logic REG_MAX_LENGTH = 1'b0;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_EMPTY    = 4'd1;
	localparam logic [3:0] ST_TOO_LONG = 4'd2;
	localparam logic [3:0] ST_NULL     = 4'd3;
	localparam logic [3:0] ST_BSLASH   = 4'd4;
	localparam logic [3:0] ST_ABSOLUTE = 4'd5;
	localparam logic [3:0] ST_DRIVE    = 4'd6;
	localparam logic [3:0] ST_DOTDOT   = 4'd7;
	localparam logic [3:0] ST_NOTHING  = 4'd8;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_DOT1  = 4'b0010,
		PH_DOT2  = 4'b0100,
		PH_NAME  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic nul;
		logic bslash;
		logic absol;
		logic drive;
		logic dotdot;
	} err_flags_t;

	// Command for the back end: the words one input byte causes.
	typedef struct packed {
		logic       slash;
		logic [1:0] ndots;
		logic       has_char;
		logic [7:0] ch;
		logic       verdict;
		logic [3:0] status;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic nonempty;
		cmd_t cmd;
	} q_rd_t;

endpackage

`default_nettype wire

// ===== src/rpn_if.sv =====
// -----------------------------------------------------------------------------
// rpn_if
// Valid/ready channels for path bytes in and normalised words out.
// -----------------------------------------------------------------------------
`default_nettype none

interface rpn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       no_char;
	logic       last;

	modport source (output valid, char_code, no_char, last, input ready);
	modport sink (input valid, char_code, no_char, last, output ready);
endinterface

interface rpn_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       path_done;
	logic [3:0] status;
	logic       run_last;

	modport source (output valid, out_char, char_valid, path_done, status, run_last,
		input ready);
	modport sink (input valid, out_char, char_valid, path_done, status, run_last,
		output ready);
endinterface

`default_nettype wire

// ===== src/rpn_front.sv =====
// -----------------------------------------------------------------------------
// rpn_front
// Classifies each path byte, tracks segment state and errors, issues commands.
// -----------------------------------------------------------------------------
`default_nettype none

module rpn_front import rpn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [LEN_W-1:0] max_length,
	input  wire logic             q_full,
	rpn_in_if.sink                chars,
	output q_wr_t                 q_wr
);

	phase_t             phase_q, phase_n, phase_c;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               emitted_q, emitted_n;
	err_flags_t         flags_q, flags_n;
	cmd_t               cmd;
	logic               accept;
	logic [7:0]         c;

	assign chars.ready = !q_full;
	assign accept      = chars.valid && chars.ready;
	assign c           = chars.char_code;

	always_comb begin
		phase_c   = phase_q;
		cnt_n     = cnt_q;
		emitted_n = emitted_q;
		flags_n   = flags_q;
		cmd       = '0;
		if (!chars.no_char) begin
			if (cnt_q != CNT_MAX) begin
				cnt_n = cnt_q + 1'b1;
			end
			if (c == CH_NUL) flags_n.nul = 1'b1;
			if (c == CH_BSLASH) flags_n.bslash = 1'b1;
			if (cnt_q == '0 && c == CH_SLASH) flags_n.absol = 1'b1;
			if (cnt_q == CNT_W'(1) && c == CH_COLON) flags_n.drive = 1'b1;
			if (c == CH_SLASH) begin
				if (phase_q == PH_DOT2) flags_n.dotdot = 1'b1;
				phase_c = PH_START;
			end else if (c == CH_DOT && phase_q == PH_START) begin
				phase_c = PH_DOT1;
			end else if (c == CH_DOT && phase_q == PH_DOT1) begin
				phase_c = PH_DOT2;
			end else begin
				if (phase_q == PH_DOT1) cmd.ndots = 2'd1;
				else if (phase_q == PH_DOT2) cmd.ndots = 2'd2;
				if (phase_q != PH_NAME) begin
					cmd.slash = emitted_q;
					emitted_n = 1'b1;
				end
				cmd.has_char = 1'b1;
				cmd.ch       = c;
				phase_c      = PH_NAME;
			end
		end
		phase_n = phase_c;
		if (chars.last) begin
			if (phase_c == PH_DOT2) flags_n.dotdot = 1'b1;
			cmd.verdict = 1'b1;
			if (cnt_n == '0) cmd.status = ST_EMPTY;
			else if (cnt_n > {1'b0, max_length}) cmd.status = ST_TOO_LONG;
			else if (flags_n.nul) cmd.status = ST_NULL;
			else if (flags_n.bslash) cmd.status = ST_BSLASH;
			else if (flags_n.absol) cmd.status = ST_ABSOLUTE;
			else if (flags_n.drive) cmd.status = ST_DRIVE;
			else if (flags_n.dotdot) cmd.status = ST_DOTDOT;
			else if (!emitted_n) cmd.status = ST_NOTHING;
			else cmd.status = ST_OK;
			phase_n   = PH_START;
			cnt_n     = '0;
			emitted_n = 1'b0;
			flags_n   = '0;
		end
	end

	assign q_wr.push = accept && (cmd.has_char || cmd.verdict);
	assign q_wr.cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			cnt_q     <= '0;
			emitted_q <= 1'b0;
			flags_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			cnt_q     <= cnt_n;
			emitted_q <= emitted_n;
			flags_q   <= flags_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/rpn_queue.sv =====
// -----------------------------------------------------------------------------
// rpn_queue
// Short command queue between the front and back ends.
// -----------------------------------------------------------------------------
`default_nettype none

module rpn_queue import rpn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire q_wr_t q_wr,
	input  wire logic  pop,
	output logic       full,
	output q_rd_t      q_rd
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_pop;

	assign full        = (count_q == QCW'(QDEPTH));
	assign q_rd.nonempty = (count_q != '0);
	assign q_rd.cmd    = mem_q[rd_ptr_q];
	assign do_pop      = pop && q_rd.nonempty;

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (q_wr.push && !do_pop) count_q <= count_q + 1'b1;
			else if (!q_wr.push && do_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/rpn_back.sv =====
// -----------------------------------------------------------------------------
// rpn_back
// Expands each command into words, one word per cycle unless the output stalls.
// -----------------------------------------------------------------------------
`default_nettype none

module rpn_back import rpn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire q_rd_t q_rd,
	output logic       pop,
	rpn_out_if.source  results
);

	cmd_t       cur_q, cur_n;
	logic       cur_valid_q;
	logic       can_emit, final_word;
	logic       out_valid_q;
	logic [7:0] out_char_q, ch_n;
	logic       char_valid_q, path_done_q, run_last_q;
	logic [3:0] status_q;

	assign can_emit = cur_valid_q && (!out_valid_q || results.ready);

	always_comb begin
		cur_n = cur_q;
		ch_n  = '0;
		if (cur_q.slash) begin
			ch_n        = CH_SLASH;
			cur_n.slash = 1'b0;
		end else if (cur_q.ndots != '0) begin
			ch_n        = CH_DOT;
			cur_n.ndots = cur_q.ndots - 1'b1;
		end else if (cur_q.has_char) begin
			ch_n           = cur_q.ch;
			cur_n.has_char = 1'b0;
		end else begin
			cur_n.verdict = 1'b0;
		end
	end

	assign final_word = !cur_n.slash && cur_n.ndots == '0 && !cur_n.has_char
		&& !cur_n.verdict;
	assign pop = q_rd.nonempty && (!cur_valid_q || (can_emit && final_word));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) cur_valid_q <= 1'b1;
			else if (can_emit && final_word) cur_valid_q <= 1'b0;
			if (can_emit) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_rd.cmd;
		end else if (can_emit) begin
			cur_q <= cur_n;
		end
		if (can_emit) begin
			out_char_q   <= ch_n;
			char_valid_q <= !cur_q.verdict || cur_q.has_char || cur_q.slash
				|| cur_q.ndots != '0;
			path_done_q  <= !(cur_q.has_char || cur_q.slash || cur_q.ndots != '0);
			status_q     <= (cur_q.has_char || cur_q.slash || cur_q.ndots != '0)
				? ST_OK : cur_q.status;
			run_last_q   <= final_word;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_char   = out_char_q;
	assign results.char_valid = char_valid_q;
	assign results.path_done  = path_done_q;
	assign results.status     = status_q;
	assign results.run_last   = run_last_q;

endmodule

`default_nettype wire

// ===== src/relative_path_normaliser.sv =====
// -----------------------------------------------------------------------------
// relative_path_normaliser
// Streams a relative path in normalised form and ends it with a verdict word.
// -----------------------------------------------------------------------------
// A byte's command goes into the command queue, then the back end's current
// command register; its words leave through the output register. Throughput:
// one byte per cycle while the queue is not full; a byte that causes k words
// holds the back end for them all, and the four-entry queue absorbs such bursts.
// Reset: max_length returns to 4096, path state clears and the queue empties.
`default_nettype none

module relative_path_normaliser import rpn_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	rpn_in_if.sink                     chars,
	rpn_out_if.source                  results,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic [LEN_W-1:0] max_length_q;
	q_wr_t            q_wr;
	q_rd_t            q_rd;
	logic             q_full, pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_LENGTH)
		? {{(CFG_DATA_W-LEN_W){1'b0}}, max_length_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LENGTH) begin
			max_length_q <= pwdata[LEN_W-1:0];
		end
	end

	rpn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_length (max_length_q),
		.q_full     (q_full),
		.chars      (chars),
		.q_wr       (q_wr)
	);

	rpn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.full   (q_full),
		.q_rd   (q_rd)
	);

	rpn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rd    (q_rd),
		.pop     (pop),
		.results (results)
	);

endmodule

`default_nettype wire

// ===== src/rpn_checker.sv =====
// -----------------------------------------------------------------------------
// rpn_checker
// Port-level checks on the output words of the path normaliser.
// -----------------------------------------------------------------------------
`default_nettype none

module rpn_checker import rpn_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       valid,
	input wire logic       ready,
	input wire logic [7:0] out_char,
	input wire logic       char_valid,
	input wire logic       path_done,
	input wire logic [3:0] status,
	input wire logic       run_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid
		&& $stable({out_char, char_valid, path_done, status, run_last}))
		else $error("output word changed while stalled");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		valid && path_done |-> !char_valid && out_char == CH_NUL && run_last)
		else $error("malformed verdict word");

	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid && char_valid |-> !path_done && status == ST_OK)
		else $error("byte word carries a verdict");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (char_valid != path_done) && status <= ST_NOTHING)
		else $error("word is neither byte nor verdict, or status out of range");

endmodule

bind relative_path_normaliser rpn_checker u_rpn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (results.valid),
	.ready      (results.ready),
	.out_char   (results.out_char),
	.char_valid (results.char_valid),
	.path_done  (results.path_done),
	.status     (results.status),
	.run_last   (results.run_last)
);

`default_nettype wire

// ===== verif/relative_path_normaliser_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// relative_path_normaliser_test
// Self-checking bench for the relative path normaliser. Paths go in one byte
// per word, with random bursts and gaps on the input and random stalls on the
// output. A scoreboard tracks the segment phase, the byte count and the error
// flags, predicts every normalised byte and verdict word, and compares each
// word that leaves the block. A short directed part covers each error and the
// dot handling. Random paths follow under several length limits.
// -----------------------------------------------------------------------------

module relative_path_normaliser_test;
	import rpn_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam logic [CFG_ADDR_W-1:0] MAX_LENGTH_ADDR = CFG_ADDR_W'(4 * REG_MAX_LENGTH);

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       path_done;
		logic [3:0] status;
		logic       run_last;
	} result_word_t;

	class path_scoreboard;
		phase_t               seg_phase;
		logic [CNT_W-1:0]     byte_count;
		logic                 emitted_any;
		err_flags_t           flags;
		logic [LEN_W-1:0]     max_length;
		result_word_t         expected_words[$];
		int                   mismatches;
		int                   words_checked;
		int                   verdicts;
		int                   bytes_seen;

		function new();
			max_length = MAX_LENGTH_RST;
			clear_path();
		endfunction

		function void clear_path();
			seg_phase = PH_START;
			byte_count = '0;
			emitted_any = 1'b0;
			flags = '0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void close_segment();
			if (seg_phase == PH_DOT2) flags.dotdot = 1'b1;
			seg_phase = PH_START;
		endfunction

		function result_word_t byte_word(input logic [7:0] c);
			return '{out_char: c, char_valid: 1'b1, path_done: 1'b0, status: ST_OK,
				run_last: 1'b0};
		endfunction

		function void note_item(input logic [7:0] c, input logic none, input logic lst);
			result_word_t     burst[$];
			logic [CNT_W-1:0] pos;
			logic [1:0]       dots;
			logic [3:0]       st;
			if (!none) begin
				pos = byte_count;
				bytes_seen++;
				if (byte_count != CNT_MAX) byte_count++;
				if (c == CH_NUL) flags.nul = 1'b1;
				if (c == CH_BSLASH) flags.bslash = 1'b1;
				if (pos == 0 && c == CH_SLASH) flags.absol = 1'b1;
				if (pos == 1 && c == CH_COLON) flags.drive = 1'b1;
				if (c == CH_SLASH) begin
					close_segment();
				end else if (c == CH_DOT && seg_phase == PH_START) begin
					seg_phase = PH_DOT1;
				end else if (c == CH_DOT && seg_phase == PH_DOT1) begin
					seg_phase = PH_DOT2;
				end else begin
					dots = (seg_phase == PH_DOT1) ? 2'd1
						: (seg_phase == PH_DOT2) ? 2'd2 : 2'd0;
					if (seg_phase != PH_NAME) begin
						if (emitted_any) burst.insert(burst.size(), byte_word(CH_SLASH));
						emitted_any = 1'b1;
					end
					repeat (dots) burst.insert(burst.size(), byte_word(CH_DOT));
					burst.insert(burst.size(), byte_word(c));
					seg_phase = PH_NAME;
				end
			end
			if (lst) begin
				close_segment();
				if (byte_count == 0) st = ST_EMPTY;
				else if (byte_count > CNT_W'(max_length)) st = ST_TOO_LONG;
				else if (flags.nul) st = ST_NULL;
				else if (flags.bslash) st = ST_BSLASH;
				else if (flags.absol) st = ST_ABSOLUTE;
				else if (flags.drive) st = ST_DRIVE;
				else if (flags.dotdot) st = ST_DOTDOT;
				else if (!emitted_any) st = ST_NOTHING;
				else st = ST_OK;
				burst.insert(burst.size(), '{out_char: 8'h00, char_valid: 1'b0,
					path_done: 1'b1, status: st, run_last: 1'b0});
				verdicts++;
				clear_path();
			end
			if (burst.size() != 0) burst[burst.size() - 1].run_last = 1'b1;
			expected_words = {expected_words, burst};
		endfunction

		task report(input string msg);
			if (mismatches < 40) $display("ERROR: %s", msg);
			mismatches++;
		endtask

		task check_word(input result_word_t got);
			result_word_t want;
			string        diff;
			words_checked++;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word %0d: %02h/%0b/%0b/%0d/%0b",
					words_checked, got.out_char, got.char_valid, got.path_done,
					got.status, got.run_last));
				return;
			end
			want = expected_words.pop_front();
			diff = "";
			if (got.out_char !== want.out_char) diff = {diff, " out_char"};
			if (got.char_valid !== want.char_valid) diff = {diff, " char_valid"};
			if (got.path_done !== want.path_done) diff = {diff, " path_done"};
			if (got.status !== want.status) diff = {diff, " status"};
			if (got.run_last !== want.run_last) diff = {diff, " run_last"};
			if (diff != "") begin
				report($sformatf("word %0d:%s got %02h/%0b/%0b/%0d/%0b want %02h/%0b/%0b/%0d/%0b",
					words_checked, diff,
					got.out_char, got.char_valid, got.path_done, got.status, got.run_last,
					want.out_char, want.char_valid, want.path_done, want.status, want.run_last));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	rpn_in_if  chars ();
	rpn_out_if results ();

	path_scoreboard sb = new();

	int         burst_left = 0;
	int         random_items = 0;
	int         settings = 0;
	int         cycle_count = 0;
	int         stall_epoch = 0;
	logic [7:0] stall_mask = 8'hFF;
	logic [2:0] stall_step = 3'd0;

	relative_path_normaliser i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("relative_path_normaliser: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars.valid && chars.ready) begin
				sb.note_item(chars.char_code, chars.no_char, chars.last);
			end
			if (results.valid && results.ready) begin
				sb.check_word({results.out_char, results.char_valid, results.path_done,
					results.status, results.run_last});
			end
		end
	end

	initial begin
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_epoch == 0) begin
				stall_epoch = $urandom_range(20, 80);
				stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			end
			stall_epoch--;
			results.ready <= stall_mask[stall_step];
			stall_step++;
		end
	end

	function automatic logic [7:0] name_byte();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
			: 8'("a" + $urandom_range(0, 25));
	endfunction

	task automatic send_item(input logic [7:0] code, input logic none, input logic lst);
		if (burst_left == 0) begin
			chars.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		chars.valid <= 1'b1;
		chars.char_code <= code;
		chars.no_char <= none;
		chars.last <= lst;
		do @(posedge clk); while (!chars.ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_path(input string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, i == s.len() - 1);
	endtask

	task automatic send_random_path();
		logic [7:0] bytes[$];
		int         nseg;
		logic       marker_end;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) bytes = {bytes, 8'($urandom_range(0, 255))};
		end else begin
			if ($urandom_range(0, 11) == 0) bytes = {bytes, CH_SLASH};
			if ($urandom_range(0, 11) == 0) begin
				bytes = {bytes, 8'("a" + $urandom_range(0, 25))};
				bytes = {bytes, CH_COLON};
			end
			nseg = $urandom_range(1, 4);
			for (int s = 0; s < nseg; s++) begin
				if (s != 0) repeat (($urandom_range(0, 4) == 0) ? 2 : 1) bytes = {bytes, CH_SLASH};
				case ($urandom_range(0, 7))
					0: bytes = {bytes, CH_DOT};
					1: begin
						bytes = {bytes, CH_DOT};
						bytes = {bytes, CH_DOT};
					end
					2: ;
					3: begin
						bytes = {bytes, CH_DOT};
						bytes = {bytes, CH_DOT};
						bytes = {bytes, name_byte()};
					end
					default: repeat ($urandom_range(1, 5)) bytes = {bytes, name_byte()};
				endcase
			end
			if ($urandom_range(0, 5) == 0) bytes = {bytes, CH_SLASH};
			if (bytes.size() != 0 && $urandom_range(0, 15) == 0)
				bytes[$urandom_range(0, bytes.size() - 1)] = CH_BSLASH;
			if (bytes.size() != 0 && $urandom_range(0, 15) == 0)
				bytes[$urandom_range(0, bytes.size() - 1)] = CH_NUL;
		end
		marker_end = (bytes.size() == 0) || ($urandom_range(0, 5) == 0);
		foreach (bytes[i]) begin
			if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b1, 1'b0);
			send_item(bytes[i], 1'b0, !marker_end && i == bytes.size() - 1);
			random_items++;
		end
		if (marker_end) begin
			send_item(8'($urandom), 1'b1, 1'b1);
			random_items++;
		end
	endtask

	task automatic wait_for_results();
		chars.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic read_check(input logic [LEN_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MAX_LENGTH_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[LEN_W-1:0] !== want)
			sb.report($sformatf("max_length reads %0d, expected %0d", prdata[LEN_W-1:0], want));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_max_length(input logic [LEN_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAX_LENGTH_ADDR;
		pwdata <= {(CFG_DATA_W - LEN_W)'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.max_length = value;
		settings++;
		@(negedge clk);
		read_check(value);
	endtask

	initial begin
		logic [LEN_W-1:0] limit;
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.char_code = 8'h00;
		chars.no_char = 1'b0;
		chars.last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		read_check(MAX_LENGTH_RST);
		send_item(8'($urandom), 1'b1, 1'b1);
		send_item(8'($urandom), 1'b1, 1'b0);
		send_path("a");
		send_path("/a");
		send_path("c:");
		send_path("..");
		send_path("./");
		send_path("..x");
		send_path("a//.b/");
		send_item(CH_NUL, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_path("\\");
		send_item("a", 1'b0, 1'b0);
		send_item(8'($urandom), 1'b1, 1'b1);

		wait_for_results();
		program_max_length(16'd0);
		send_path("a");
		send_item(8'($urandom), 1'b1, 1'b1);
		wait_for_results();
		program_max_length(16'd1);
		send_path("a");
		send_path("ab");
		wait_for_results();
		program_max_length(16'hFFFF);
		send_path("a/./b");

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: limit = LEN_W'($urandom_range(2, 8));
				1: limit = LEN_W'($urandom_range(12, 24));
				2: limit = LEN_W'($urandom);
				3: limit = LEN_W'($urandom_range(1, 4));
				default: limit = LEN_W'($urandom_range(6, 16));
			endcase
			wait_for_results();
			program_max_length(limit);
			while (random_items < 55 * (p + 1)) send_random_path();
		end
		wait_for_results();

		$display("Covered %0d bytes in %0d paths and %0d result words over %0d length limits,",
			sb.bytes_seen, sb.verdicts, sb.words_checked, settings);
		$display("among them a zero limit and the widest limit.");
		if (sb.mismatches == 0) begin
			$display("relative_path_normaliser: match");
		end else begin
			$display("relative_path_normaliser: mismatch");
		end
		$finish;
	end

endmodule
